[sv/gtr_pkg.sv]
// Package: shared types, command codes and bus constants of the glyph text renderer.
package gtr_pkg;

  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_BYTE  = 3'd1;
  localparam logic [2:0] CMD_NLINE = 3'd2;
  localparam logic [2:0] CMD_SETC  = 3'd3;
  localparam logic [2:0] CMD_SKIP  = 3'd4;

  localparam logic [1:0] REG_CHAR_SIZE  = 2'd0;
  localparam logic [1:0] REG_FORE_COLOR = 2'd1;
  localparam logic [1:0] REG_BACK_COLOR = 2'd2;

  localparam logic [6:0] CHAR_SIZE_MIN   = 7'd8;
  localparam logic [6:0] CHAR_SIZE_RESET = 7'd16;
  localparam logic [15:0] FORE_RESET     = 16'h0000;
  localparam logic [15:0] BACK_RESET     = 16'hffff;

  localparam logic [11:0] ROW_MAX = 12'd2047;
  localparam logic [10:0] COL_MAX = 11'd1023;

  localparam logic [15:0] MEM_WRITE_CMD = 16'h2c00;
  localparam logic [7:0]  BYTE_MASK     = 8'hff;

  localparam int FIFO_DEPTH = 2;

  typedef logic [15:0] win_regs_t [8];
  localparam win_regs_t WIN_REGS = '{
    16'h2a00, 16'h2a01, 16'h2a02, 16'h2a03,
    16'h2b00, 16'h2b01, 16'h2b02, 16'h2b03
  };

  typedef struct packed {
    logic [2:0] command;
    logic       wide_glyph;
    logic [7:0] glyph_byte;
    logic [9:0] new_row;
    logic [8:0] new_col;
    logic [7:0] skip_count;
  } gtr_in_t;

  typedef struct packed {
    logic        is_command;
    logic [15:0] bus_word;
    logic        last;
  } gtr_out_t;

  typedef struct packed {
    logic [6:0]  char_size;
    logic [15:0] fore_color;
    logic [15:0] back_color;
  } gtr_cfg_t;

  typedef struct packed {
    logic        is_window;
    logic [9:0]  c0;
    logic [10:0] c1;
    logic [10:0] r0;
    logic [11:0] r1;
    logic [7:0]  pix;
  } gtr_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gtr_fifo_stat_t;

endpackage

[sv/gtr_front.sv]
// Front end: accepts commands, keeps the cursor and glyph state, queues bus jobs.
module gtr_front #(
  parameter int SCREEN_COLS = 480,
  parameter int SCREEN_ROWS = 800
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  gtr_pkg::gtr_in_t        in_data,
  input  gtr_pkg::gtr_cfg_t       cfg,
  input  gtr_pkg::gtr_fifo_stat_t fifo_stat,
  output logic                    push,
  output gtr_pkg::gtr_job_t       push_job
);
  import gtr_pkg::*;

  localparam logic [11:0] COLS_L = 12'(SCREEN_COLS);
  localparam logic [11:0] ROWS_L = 12'(SCREEN_ROWS);

  logic [10:0] row_r, row_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [9:0]  left_r, left_nxt;
  logic        wide_r, wide_nxt;
  logic        drop_r, drop_nxt;
  logic [7:0]  adv_r, adv_nxt;

  logic        accept;
  logic [6:0]  s;
  logic [6:0]  half;
  logic [6:0]  w;
  logic        wrap;
  logic [10:0] row_b;
  logic [9:0]  col_b;
  logic        drop_b;
  logic [13:0] prod;
  logic [10:0] c_step;
  logic [9:0]  col_s;
  logic        step_wrap;
  logic [10:0] row_s;

  function automatic logic [10:0] row_add(input logic [10:0] r, input logic [6:0] v);
    logic [11:0] sum;
    sum = {1'b0, r} + {5'b0, v};
    row_add = (sum > ROW_MAX) ? ROW_MAX[10:0] : sum[10:0];
  endfunction

  assign in_stall = (adv_r != 8'd0) | fifo_stat.full;
  assign accept   = in_valid & ~in_stall;

  assign s    = cfg.char_size;
  assign half = {1'b0, s[6:1]};
  assign w    = in_data.wide_glyph ? s : half;
  assign wrap = ({2'b0, col_r} + {5'b0, w}) > COLS_L;
  assign row_b  = wrap ? row_add(row_r, s) : row_r;
  assign col_b  = wrap ? 10'd0 : col_r;
  assign drop_b = ({1'b0, row_b} + {5'b0, s}) > ROWS_L;
  assign prod   = 14'(s) * 14'(w);

  assign c_step    = {1'b0, col_r} + {4'b0, half};
  assign col_s     = (c_step > COL_MAX) ? COL_MAX[9:0] : c_step[9:0];
  assign step_wrap = ({2'b0, col_s} + {5'b0, half}) > COLS_L;
  assign row_s     = row_add(row_r, s);

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    left_nxt = left_r;
    wide_nxt = wide_r;
    drop_nxt = drop_r;
    adv_nxt  = adv_r;
    push     = 1'b0;
    push_job = '0;
    if (adv_r != 8'd0) begin
      if (step_wrap) begin
        row_nxt = row_s;
        col_nxt = 10'd0;
        adv_nxt = (({1'b0, row_s} + {5'b0, s}) > ROWS_L) ? 8'd0 : adv_r - 8'd1;
      end else begin
        col_nxt = col_s;
        adv_nxt = adv_r - 8'd1;
      end
    end else if (accept) begin
      case (in_data.command)
        CMD_BEGIN: begin
          row_nxt  = row_b;
          col_nxt  = col_b;
          wide_nxt = in_data.wide_glyph;
          left_nxt = prod[12:3];
          drop_nxt = drop_b;
          if (!drop_b) begin
            push               = 1'b1;
            push_job.is_window = 1'b1;
            push_job.c0        = col_b;
            push_job.c1        = {1'b0, col_b} + {4'b0, w} - 11'd1;
            push_job.r0        = row_b;
            push_job.r1        = {1'b0, row_b} + {5'b0, s} - 12'd1;
          end
        end
        CMD_BYTE: begin
          if (left_r != 10'd0) begin
            left_nxt = left_r - 10'd1;
            if (!drop_r) begin
              push               = 1'b1;
              push_job.is_window = 1'b0;
              push_job.pix       = in_data.glyph_byte;
              if (left_r == 10'd1) begin
                adv_nxt = wide_r ? 8'd2 : 8'd1;
              end
            end
          end
        end
        CMD_NLINE: begin
          row_nxt = row_s;
          col_nxt = 10'd0;
        end
        CMD_SETC: begin
          row_nxt = {1'b0, in_data.new_row};
          col_nxt = {1'b0, in_data.new_col};
        end
        CMD_SKIP: begin
          adv_nxt = in_data.skip_count;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      left_r <= '0;
      wide_r <= 1'b0;
      drop_r <= 1'b0;
      adv_r  <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      left_r <= left_nxt;
      wide_r <= wide_nxt;
      drop_r <= drop_nxt;
      adv_r  <= adv_nxt;
    end
  end

endmodule

[sv/gtr_fifo.sv]
// Job queue between the front end and the bus sequencer.
module gtr_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  gtr_pkg::gtr_job_t       push_job,
  input  logic                    pop,
  output gtr_pkg::gtr_job_t       pop_job,
  output gtr_pkg::gtr_fifo_stat_t stat
);
  import gtr_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  gtr_job_t        mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign stat.full  = (cnt_r == CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign pop_job    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ptr_inc(wp_r) : wp_r;
    rp_nxt  = do_pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/gtr_back.sv]
// Bus sequencer: turns queued jobs into window writes and pixel words.
module gtr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gtr_pkg::gtr_cfg_t       cfg,
  input  gtr_pkg::gtr_fifo_stat_t fifo_stat,
  input  gtr_pkg::gtr_job_t       pop_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output gtr_pkg::gtr_out_t       out_data
);
  import gtr_pkg::*;

  logic       busy_r, busy_nxt;
  gtr_job_t   job_r, job_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  gtr_out_t   od_r, od_nxt;

  logic       out_free;
  logic       final_word;
  gtr_out_t   word;
  logic [2:0] pair;
  logic [11:0] coord;

  assign out_free   = ~ov_r | ~out_stall;
  assign final_word = job_r.is_window ? (cnt_r == 5'd16) : (cnt_r == 5'd7);
  assign pair       = cnt_r[3:1];
  assign pop        = ~fifo_stat.empty & (~busy_r | (out_free & final_word));

  always_comb begin
    case (pair[2:1])
      2'd0:    coord = {2'b0, job_r.c0};
      2'd1:    coord = {1'b0, job_r.c1};
      2'd2:    coord = {1'b0, job_r.r0};
      default: coord = job_r.r1;
    endcase
  end

  always_comb begin
    word = '0;
    word.last = final_word;
    if (job_r.is_window) begin
      if (cnt_r[4]) begin
        word.is_command = 1'b1;
        word.bus_word   = MEM_WRITE_CMD;
      end else if (!cnt_r[0]) begin
        word.is_command = 1'b1;
        word.bus_word   = WIN_REGS[pair];
      end else begin
        word.is_command = 1'b0;
        word.bus_word   = pair[0] ? {8'h00, coord[7:0] & BYTE_MASK}
                                  : {12'h000, coord[11:8]};
      end
    end else begin
      word.is_command = 1'b0;
      word.bus_word   = job_r.pix[cnt_r[2:0]] ? cfg.fore_color : cfg.back_color;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    if (out_free) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        od_nxt  = word;
        cnt_nxt = cnt_r + 5'd1;
        if (final_word) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      job_nxt  = pop_job;
      cnt_nxt  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

[sv/glyph_text_renderer.sv]
// Top level: configuration registers, front end, job queue and bus sequencer.
// Begin glyph: 17 bus words, one per cycle unless out_stall holds the output.
// Glyph byte: 8 pixel words, one per cycle unless stalled; the queue buffers jobs.
// Skip spaces and the glyph-end advance move by half-cells and stall the input.
// Synchronous active-low reset clears the cursor, glyph state and queue and
// restores char_size 16, fore_color 0x0000, back_color 0xffff.
module glyph_text_renderer #(
  parameter int SCREEN_COLS   = 480,
  parameter int SCREEN_ROWS   = 800,
  parameter int MAX_CHAR_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gtr_pkg::gtr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gtr_pkg::gtr_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import gtr_pkg::*;

  localparam logic [6:0] SIZE_MAX = 7'(MAX_CHAR_SIZE);

  logic [6:0]  size_r, size_nxt;
  logic [15:0] fore_r, fore_nxt;
  logic [15:0] back_r, back_nxt;
  logic [6:0]  size_w;
  logic        cfg_we;

  gtr_cfg_t       cfg;
  gtr_fifo_stat_t fifo_stat;
  gtr_job_t       push_job;
  gtr_job_t       pop_job;
  logic           push;
  logic           pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign size_w    = {cfg_data[6:2], 2'b00};

  always_comb begin
    size_nxt = size_r;
    fore_nxt = fore_r;
    back_nxt = back_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CHAR_SIZE: begin
          if (size_w < CHAR_SIZE_MIN) begin
            size_nxt = CHAR_SIZE_MIN;
          end else if (size_w > SIZE_MAX) begin
            size_nxt = SIZE_MAX;
          end else begin
            size_nxt = size_w;
          end
        end
        REG_FORE_COLOR: fore_nxt = cfg_data;
        REG_BACK_COLOR: back_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CHAR_SIZE_RESET;
      fore_r <= FORE_RESET;
      back_r <= BACK_RESET;
    end else begin
      size_r <= size_nxt;
      fore_r <= fore_nxt;
      back_r <= back_nxt;
    end
  end

  assign cfg.char_size  = size_r;
  assign cfg.fore_color = fore_r;
  assign cfg.back_color = back_r;

  gtr_front #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .fifo_stat(fifo_stat),
    .push     (push),
    .push_job (push_job)
  );

  gtr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .stat    (fifo_stat)
  );

  gtr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .fifo_stat(fifo_stat),
    .pop_job  (pop_job),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[test/tb.sv]
// Testbench for glyph_text_renderer: predicts every LCD bus word and checks each transaction.
`timescale 1ns / 100ps

module tb;
  import gtr_pkg::*;

  localparam int SCREEN_COLS    = 480;
  localparam int SCREEN_ROWS    = 800;
  localparam int MAX_CHAR_SIZE  = 64;
  localparam int HALF_PERIOD    = 6;
  localparam int QUIET_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BIG_GLYPH      = 64;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
  localparam logic [1:0]  REG_NONE      = 2'd3;
  localparam logic [15:0] SIZE_MASK     = 16'h007c;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gtr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gtr_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gtr_in_t     pending_cmds [$];
  gtr_out_t    bus_words_due [$];
  idle_mode_t  idle_mode = IDLE_NONE;
  bit          in_taken = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  int unsigned cell_h, fore_c, back_c;
  int unsigned cur_row, cur_col, bytes_left;
  bit          glyph_wide, glyph_dropped;

  int n_items = 0, n_words = 0, n_cfg = 0, n_drawn = 0, n_dropped = 0, errors = 0;

  glyph_text_renderer #(
    .SCREEN_COLS  (SCREEN_COLS),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .MAX_CHAR_SIZE(MAX_CHAR_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Cursor and glyph predictor

  function automatic void bump_row(int unsigned v);
    cur_row = (cur_row + v > ROW_MAX) ? int'(ROW_MAX) : cur_row + v;
  endfunction

  function automatic void advance_cursor(int unsigned steps);
    int unsigned half;
    half = cell_h >> 1;
    for (int unsigned i = 0; i < steps; i++) begin
      cur_col = (cur_col + half > COL_MAX) ? int'(COL_MAX) : cur_col + half;
      if (cur_col + half > SCREEN_COLS) begin
        bump_row(cell_h);
        cur_col = 0;
        if (cur_row + cell_h > SCREEN_ROWS) break;
      end
    end
  endfunction

  function automatic void due_word(logic cmd, logic [15:0] word);
    gtr_out_t w;
    w.is_command = cmd;
    w.bus_word = word;
    w.last = 1'b0;
    bus_words_due.push_back(w);
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
    int unsigned s;
    case (idx)
      REG_CHAR_SIZE: begin
        s = 32'(val & SIZE_MASK);
        if (s < CHAR_SIZE_MIN) s = 32'(CHAR_SIZE_MIN);
        if (s > MAX_CHAR_SIZE) s = MAX_CHAR_SIZE;
        cell_h = s;
      end
      REG_FORE_COLOR: fore_c = 32'(val);
      REG_BACK_COLOR: back_c = 32'(val);
      default: ;
    endcase
  endfunction

  function automatic void render_item(gtr_in_t it);
    int unsigned w, n0;
    int unsigned coord [4];
    logic [7:0] bits;
    n0 = bus_words_due.size();
    case (it.command)
      CMD_BEGIN: begin
        w = it.wide_glyph ? cell_h : cell_h >> 1;
        if (cur_col + w > SCREEN_COLS) begin
          bump_row(cell_h);
          cur_col = 0;
        end
        glyph_wide = it.wide_glyph;
        bytes_left = (cell_h * w) >> 3;
        if (cur_row + cell_h > SCREEN_ROWS) begin
          glyph_dropped = 1'b1;
          n_dropped++;
        end else begin
          glyph_dropped = 1'b0;
          n_drawn++;
          coord[0] = cur_col;
          coord[1] = cur_col + w - 1;
          coord[2] = cur_row;
          coord[3] = cur_row + cell_h - 1;
          for (int k = 0; k < 8; k++) begin
            due_word(1'b1, WIN_REGS[k]);
            due_word(1'b0, 16'(k[0] ? (coord[k >> 1] & BYTE_MASK) : (coord[k >> 1] >> 8)));
          end
          due_word(1'b1, MEM_WRITE_CMD);
        end
      end
      CMD_BYTE: begin
        if (bytes_left != 0) begin
          bytes_left--;
          if (!glyph_dropped) begin
            bits = it.glyph_byte;
            for (int j = 0; j < 8; j++) due_word(1'b0, bits[j] ? 16'(fore_c) : 16'(back_c));
            if (bytes_left == 0) advance_cursor(glyph_wide ? 2 : 1);
          end
        end
      end
      CMD_NLINE: begin
        bump_row(cell_h);
        cur_col = 0;
      end
      CMD_SETC: begin
        cur_row = 32'(it.new_row);
        cur_col = 32'(it.new_col);
      end
      CMD_SKIP: advance_cursor(32'(it.skip_count));
      default: ;
    endcase
    if (bus_words_due.size() > n0) bus_words_due[bus_words_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_word(gtr_out_t got);
    gtr_out_t want;
    if (bus_words_due.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("unexpected bus word: cmd=%0b word=%04h last=%0b",
                 got.is_command, got.bus_word, got.last);
      return;
    end
    want = bus_words_due.pop_front();
    n_words++;
    if (got.is_command !== want.is_command || got.bus_word !== want.bus_word ||
        got.last !== want.last) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("word %0d expected cmd=%0b word=%04h last=%0b got cmd=%0b word=%04h last=%0b",
                 n_words, want.is_command, want.bus_word, want.last,
                 got.is_command, got.bus_word, got.last);
    end
  endfunction

  // Monitor: sample every transaction at the rising edge

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      cell_h = 32'(CHAR_SIZE_RESET);
      fore_c = 32'(FORE_RESET);
      back_c = 32'(BACK_RESET);
      cur_row = 0;
      cur_col = 0;
      bytes_left = 0;
      glyph_wide = 1'b0;
      glyph_dropped = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        n_cfg++;
      end
      if (in_taken) begin
        render_item(in_data);
        n_items++;
      end
      if (out_valid && !out_stall) check_word(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Driver: offer queued commands, hold each until accepted

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 70;
      IDLE_BOTH: return 21;
      default:   return 0;
    endcase
  endfunction

  function automatic int stall_pct();
    case (idle_mode)
      IDLE_RECV: return 70;
      IDLE_BOTH: return 21;
      default:   return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct());
    end
  end

  // Stimulus

  function automatic gtr_in_t rand_item(logic [2:0] cmd);
    logic [63:0] raw;
    gtr_in_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(gtr_in_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  function automatic int glyph_byte_count(logic wide);
    return (cell_h * (wide ? cell_h : cell_h >> 1)) >> 3;
  endfunction

  task automatic add_byte(logic [7:0] v);
    gtr_in_t it;
    it = rand_item(CMD_BYTE);
    it.glyph_byte = v;
    pending_cmds.push_back(it);
  endtask

  task automatic add_bytes(int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom));
  endtask

  task automatic add_begin(logic wide);
    gtr_in_t it;
    it = rand_item(CMD_BEGIN);
    it.wide_glyph = wide;
    pending_cmds.push_back(it);
  endtask

  task automatic add_setc(logic [9:0] r, logic [8:0] c);
    gtr_in_t it;
    it = rand_item(CMD_SETC);
    it.new_row = r;
    it.new_col = c;
    pending_cmds.push_back(it);
  endtask

  task automatic add_skip(logic [7:0] n);
    gtr_in_t it;
    it = rand_item(CMD_SKIP);
    it.skip_count = n;
    pending_cmds.push_back(it);
  endtask

  task automatic add_directed();
    add_begin(1'b0);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(8'h01);
    add_byte(8'h80);
    add_byte(8'h55);
    add_setc(10'd0, 9'd476);
    add_begin(1'b1);
    add_bytes(3);
    add_skip(8'd1);
    add_bytes(5);
    add_skip(8'd0);
    add_skip(8'd255);
    add_setc(10'h3ff, 9'h1ff);
    pending_cmds.push_back(rand_item(CMD_NLINE));
    add_begin(1'b1);
    add_bytes(2);
    add_begin(1'b0);
    pending_cmds.push_back(rand_item(CMD_UNUSED_LO));
    pending_cmds.push_back(rand_item(CMD_UNUSED_HI));
  endtask

  task automatic add_random(int budget);
    int added, r, n, full;
    logic wide;
    added = 0;
    while (added < budget) begin
      r = $urandom_range(0, 99);
      wide = 1'($urandom_range(0, 1));
      full = glyph_byte_count(wide);
      if (r < 70) begin
        if ($urandom_range(0, 2) == 0) begin
          add_setc(10'($urandom_range(0, SCREEN_ROWS - 1)),
                   9'($urandom_range(0, SCREEN_COLS - 1)));
          added++;
        end
        n = (full > BIG_GLYPH) ? $urandom_range(1, BIG_GLYPH) : full;
        add_begin(wide);
        add_bytes(n);
        added += n + 1;
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0: pending_cmds.push_back(rand_item(CMD_NLINE));
          1: add_skip(8'($urandom_range(0, 7)));
          default: add_skip(8'($urandom_range(0, 255)));
        endcase
        added++;
      end else if (r < 88) begin
        n = $urandom_range(0, (full > BIG_GLYPH ? BIG_GLYPH : full) - 1);
        add_begin(wide);
        add_bytes(n);
        added += n + 1;
      end else begin
        pending_cmds.push_back(rand_item(3'($urandom_range(0, 7))));
        added++;
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || bus_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic start_phase(idle_mode_t m, logic [15:0] size_val, logic [15:0] fg,
                             logic [15:0] bg);
    drain();
    repeat (QUIET_CYCLES) @(posedge clk);
    idle_mode = m;
    write_reg(REG_CHAR_SIZE, size_val);
    write_reg(REG_FORE_COLOR, fg);
    write_reg(REG_BACK_COLOR, bg);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    start_phase(IDLE_NONE, 16'h0003, 16'hffff, 16'h0000);
    add_directed();

    start_phase(IDLE_NONE, 16'h000d, 16'($urandom), 16'($urandom));
    add_random(30);
    drain();
    add_random(30);
    hold_req = 1'b1;

    start_phase(IDLE_SEND, 16'h0010, 16'h0000, 16'hffff);
    add_random(60);

    start_phase(IDLE_RECV, 16'h0008, 16'($urandom), 16'($urandom));
    write_reg(REG_NONE, 16'($urandom));
    add_random(60);

    start_phase(IDLE_BOTH, 16'h0016, 16'($urandom), 16'($urandom));
    add_random(50);

    start_phase(IDLE_SEND, 16'hffff, 16'($urandom), 16'($urandom));
    add_random(40);

    drain();
    repeat (QUIET_CYCLES) @(posedge clk);
    $display("covered %0d commands, %0d register writes, %0d glyphs drawn, %0d dropped",
             n_items, n_cfg, n_drawn, n_dropped);
    $display("checked %0d bus words across six size and idling settings, %0d errors",
             n_words, errors);
    if (errors == 0 && bus_words_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d bus words never arrived", bus_words_due.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule
